// File: src/row_indirection_table_assert.svh
// ----------------------------------------------------------------------------
// Row indirection table assertion macros
// Concurrent checks on the clock and reset of the including module.
// ----------------------------------------------------------------------------
`ifndef ROW_INDIRECTION_TABLE_ASSERT_SVH
`define ROW_INDIRECTION_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check that is held off while reset is high
`define RIT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also runs through reset
`define RIT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RIT_ASSERT(lbl, prop, msg)
`define RIT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/rit_pkg.sv
// ----------------------------------------------------------------------------
// rit_pkg
// Types and constants shared by the row indirection table modules.
// ----------------------------------------------------------------------------
package rit_pkg;

   localparam int ENTRIES_DEFAULT  = 32;
   localparam int ROW_BITS_DEFAULT = 17;

   localparam int OP_BITS    = 2;
   localparam int DELAY_BITS = 7;

   localparam int DRAIN_DELAY       = 4 * 10;
   localparam int SWAP_BUFFER_DELAY = 4 * 10;
   localparam logic [DELAY_BITS-1:0] SWAP_DELAY =
      DELAY_BITS'(DRAIN_DELAY + SWAP_BUFFER_DELAY);

   typedef enum logic [OP_BITS-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   // control part of a beat moving down the cell chain
   typedef struct packed {
      logic            vld;
      logic [OP_BITS-1:0] op;
      logic            found;
      logic            done;
   } ctl_type;

endpackage

// File: src/rit_cell.sv
// ----------------------------------------------------------------------------
// rit_cell
// One table entry plus one pipeline stage; the beat passing through checks
// or claims this entry, or clears it.
// ----------------------------------------------------------------------------
module rit_cell
   import rit_pkg::*;
#(
   parameter int ROW_BITS = ROW_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  ctl_type             ctl_in,
   input  logic [ROW_BITS-1:0] src_in,
   input  logic [ROW_BITS-1:0] dst_in,
   output ctl_type             ctl_out,
   output logic [ROW_BITS-1:0] src_out,
   output logic [ROW_BITS-1:0] dst_out
);

   logic                entry_vld_ff;
   logic                entry_vld_in;
   logic [ROW_BITS-1:0] first_row_ff;
   logic [ROW_BITS-1:0] second_row_ff;
   ctl_type             ctl_ff;
   ctl_type             ctl_nxt_in;
   logic [ROW_BITS-1:0] src_ff;
   logic [ROW_BITS-1:0] dst_ff;
   logic                hit;
   logic                take;

   always_comb begin
      hit  = entry_vld_ff && ((first_row_ff == src_in) || (second_row_ff == src_in));
      take = ctl_in.vld && (ctl_in.op == OP_INSERT) && !ctl_in.done && !entry_vld_ff;

      ctl_nxt_in       = ctl_in;
      ctl_nxt_in.found = ctl_in.found | ((ctl_in.op == OP_LOOKUP) && hit);
      ctl_nxt_in.done  = ctl_in.done | take;

      entry_vld_in = entry_vld_ff;
      if (take) begin
         entry_vld_in = 1'b1;
      end
      if (ctl_in.vld && (ctl_in.op == OP_CLEAR)) begin
         entry_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= 1'b0;
         ctl_ff       <= '0;
      end else if (enable) begin
         entry_vld_ff <= entry_vld_in;
         ctl_ff       <= ctl_nxt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         src_ff <= src_in;
         dst_ff <= dst_in;
         if (take) begin
            first_row_ff  <= src_in;
            second_row_ff <= dst_in;
         end
      end
   end

   assign ctl_out = ctl_ff;
   assign src_out = src_ff;
   assign dst_out = dst_ff;

endmodule

// File: src/row_indirection_table.sv
// ----------------------------------------------------------------------------
// row_indirection_table
// Row indirection table of one memory bank: lookup, swap insert, clear.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per beat (lookup, insert swap pair, clear);
//   rsp_* returns exactly one result beat per request, in order.
//   Each entry lives in its own cell; a beat walks the chain of ENTRIES
//   cells, one cell per cycle unless the chain holds, so every beat sees
//   the table as left by all earlier beats. The lowest free cell a swap
//   reaches takes the pair.
//   Throughput: one beat per cycle while req_stall is low; a new beat enters while older ones
//   are still walking the chain.
//   The last cell's register is the result register. While a result is
//   valid and rsp_stall is high, the whole chain holds and req_stall is
//   raised in the same cycle.
//   Reset empties the table at once (all valid bits drop) and drops
//   every beat in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module row_indirection_table
   import rit_pkg::*;
#(
   parameter int ENTRIES  = ENTRIES_DEFAULT,
   parameter int ROW_BITS = ROW_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_BITS-1:0]    req_operation,
   input  logic [ROW_BITS-1:0]   req_source_row,
   input  logic [ROW_BITS-1:0]   req_dest_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic                  rsp_inserted,
   output logic [DELAY_BITS-1:0] rsp_delay_cycles
);

   ctl_type             ctl_chain [ENTRIES+1];
   logic [ROW_BITS-1:0] src_chain [ENTRIES+1];
   logic [ROW_BITS-1:0] dst_chain [ENTRIES+1];
   logic                enable;

   assign req_stall = rsp_valid && rsp_stall;
   assign enable    = !req_stall;

   // fields: vld, op, found, done
   assign ctl_chain[0] = {req_valid, req_operation, 1'b0, 1'b0};
   assign src_chain[0] = req_source_row;
   assign dst_chain[0] = req_dest_row;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      rit_cell #(
         .ROW_BITS (ROW_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .ctl_in  (ctl_chain[k]),
         .src_in  (src_chain[k]),
         .dst_in  (dst_chain[k]),
         .ctl_out (ctl_chain[k+1]),
         .src_out (src_chain[k+1]),
         .dst_out (dst_chain[k+1])
      );
   end

   assign rsp_valid        = ctl_chain[ENTRIES].vld;
   assign rsp_found        = ctl_chain[ENTRIES].found;
   assign rsp_inserted     = ctl_chain[ENTRIES].done;
   assign rsp_delay_cycles = rsp_inserted ? SWAP_DELAY : '0;

`include "row_indirection_table_assert.svh"

   `RIT_ASSERT_ALWAYS(a_reset_empty, $fell(reset) |-> !rsp_valid, "result valid right after reset")
   `RIT_ASSERT(a_found_xor_ins, rsp_valid |-> !(rsp_found && rsp_inserted), "found and inserted together")
   `RIT_ASSERT(a_stall_cause, req_stall |-> (rsp_valid && rsp_stall), "request stalled without held result")
   `RIT_ASSERT(a_done_only_ins, rsp_valid && rsp_inserted |-> ctl_chain[ENTRIES].op == OP_INSERT, "insert flag on non-insert beat")

endmodule
